[design/chained_hash_set_insert_if_absent_top_assert.svh]
// Assertion macros shared by the hash set design files
`ifndef CHAINED_HASH_SET_INSERT_IF_ABSENT_TOP_ASSERT_SVH
`define CHAINED_HASH_SET_INSERT_IF_ABSENT_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked on clk and masked while rst_n is low
`define CHS_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hash set check failed");

// Next-cycle implication, checked on clk and masked while rst_n is low
`define CHS_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hash set check failed");

`else

`define CHS_ASSERT_IMP(name, ante, cons)
`define CHS_ASSERT_NEXT(name, ante, cons)

`endif

`endif

[design/chs_pkg.sv]
// Constants and types of the chained hash set
package chs_pkg;

    localparam int POOL_ENTRIES = 512;
    localparam int BUCKETS      = 32;
    localparam int TABLES       = 4;

    localparam int KEY_W        = 32;
    localparam int TABLE_W      = 2;
    localparam int SLOTS        = TABLES * BUCKETS;
    localparam int SLOT_W       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int POOL_IDX_W   = $clog2(POOL_ENTRIES);
    localparam int POOL_CNT_W   = $clog2(POOL_ENTRIES + 1);

    typedef struct packed {
        logic [TABLE_W-1:0] table_select;
        logic [KEY_W-1:0]   object_key;
    } chs_req_t;

    typedef struct packed {
        logic is_new;
        logic dropped;
    } chs_rsp_t;

    // One pool entry: key plus link to the next entry on the chain
    typedef struct packed {
        logic [KEY_W-1:0]      key;
        logic                  link_valid;
        logic [POOL_IDX_W-1:0] link;
    } chs_entry_t;

    typedef struct packed {
        logic                  rd_en;
        logic [SLOT_W-1:0]     rd_addr;
        logic                  wr_en;
        logic [SLOT_W-1:0]     wr_addr;
        logic [POOL_IDX_W-1:0] wr_index;
    } chs_head_cmd_t;

    typedef struct packed {
        logic                  valid;
        logic [POOL_IDX_W-1:0] index;
    } chs_head_rsp_t;

    typedef struct packed {
        logic                  rd_en;
        logic [POOL_IDX_W-1:0] rd_addr;
        logic                  wr_en;
        logic [POOL_IDX_W-1:0] wr_addr;
        chs_entry_t            wr_data;
    } chs_entry_cmd_t;

endpackage

[design/chained_hash_set_insert_if_absent_top.sv]
// Top level of the chained hash set with a shared entry pool
// Takes one item at a time: req_stall stays high until its result is loaded into the output register.
// The walk reads one pool entry per cycle from the entry RAM.
// A key found on the chain skips the insert state.
// Reset: asynchronous, active low; bucket valid bits and the allocation count clear at once,
// so items are taken after reset with no clearing pass.
`include "chained_hash_set_insert_if_absent_top_assert.svh"

module chained_hash_set_insert_if_absent_top
    import chs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_stall,
    input  chs_req_t req_item,
    output logic     rsp_valid,
    input  logic     rsp_stall,
    output chs_rsp_t rsp_item
);

    chs_head_cmd_t         head_cmd;
    chs_head_rsp_t         head_rsp;
    chs_entry_cmd_t        entry_cmd;
    chs_entry_t            entry_rdata;
    logic [POOL_IDX_W-1:0] head_rd_data;
    logic [$bits(chs_entry_t)-1:0] entry_rd_raw;
    logic [SLOTS-1:0]      head_valid_reg;
    logic                  head_hit_valid_reg;

    chs_walk_ctrl u_walk (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req_item    (req_item),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .rsp_item    (rsp_item),
        .head_cmd    (head_cmd),
        .head_rsp    (head_rsp),
        .entry_cmd   (entry_cmd),
        .entry_rdata (entry_rdata)
    );

    // Bucket head indexes
    chs_ram #(
        .WIDTH (POOL_IDX_W),
        .DEPTH (SLOTS)
    ) u_head_ram (
        .clk     (clk),
        .wr_en   (head_cmd.wr_en),
        .wr_addr (head_cmd.wr_addr),
        .wr_data (head_cmd.wr_index),
        .rd_en   (head_cmd.rd_en),
        .rd_addr (head_cmd.rd_addr),
        .rd_data (head_rd_data)
    );

    // Pool entries: key and chain link
    chs_ram #(
        .WIDTH ($bits(chs_entry_t)),
        .DEPTH (POOL_ENTRIES)
    ) u_entry_ram (
        .clk     (clk),
        .wr_en   (entry_cmd.wr_en),
        .wr_addr (entry_cmd.wr_addr),
        .wr_data (entry_cmd.wr_data),
        .rd_en   (entry_cmd.rd_en),
        .rd_addr (entry_cmd.rd_addr),
        .rd_data (entry_rd_raw)
    );

    assign entry_rdata    = chs_entry_t'(entry_rd_raw);
    assign head_rsp.valid = head_hit_valid_reg;
    assign head_rsp.index = head_rd_data;

    // Set bucket valid bits on insert; read them alongside the head RAM
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg     <= '0;
            head_hit_valid_reg <= 1'b0;
        end
        else
        begin
            if (head_cmd.wr_en)
            begin
                head_valid_reg[head_cmd.wr_addr] <= 1'b1;
            end
            if (head_cmd.rd_en)
            begin
                head_hit_valid_reg <= head_valid_reg[head_cmd.rd_addr];
            end
        end
    end

    `CHS_ASSERT_NEXT(a_head_set, head_cmd.wr_en, head_valid_reg[$past(head_cmd.wr_addr)])
    `CHS_ASSERT_IMP(a_no_rw_overlap, head_cmd.rd_en, !head_cmd.wr_en && !entry_cmd.wr_en)
    `CHS_ASSERT_NEXT(a_rsp_busy, req_valid && !req_stall, req_stall)

endmodule

[design/chs_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read
module chs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                          wr_data,
    input  logic                                      rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                          rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

[design/chs_walk_ctrl.sv]
// Chain walk and insert sequencer of the chained hash set
`include "chained_hash_set_insert_if_absent_top_assert.svh"

module chs_walk_ctrl
    import chs_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  chs_req_t       req_item,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output chs_rsp_t       rsp_item,
    output chs_head_cmd_t  head_cmd,
    input  chs_head_rsp_t  head_rsp,
    output chs_entry_cmd_t entry_cmd,
    input  chs_entry_t     entry_rdata
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_HEAD,
        S_WALK,
        S_INSERT,
        S_FINISH
    } state_t;

    state_t                state_reg,       state_next;
    logic [KEY_W-1:0]      key_reg,         key_next;
    logic [SLOT_W-1:0]     slot_reg,        slot_next;
    logic                  head_valid_reg,  head_valid_next;
    logic [POOL_IDX_W-1:0] head_index_reg,  head_index_next;
    logic [POOL_CNT_W-1:0] alloc_count_reg, alloc_count_next;
    chs_rsp_t              result_reg,      result_next;
    logic                  rsp_valid_reg,   rsp_valid_next;
    chs_rsp_t              rsp_item_reg,    rsp_item_next;

    logic                  req_table_ok;
    logic [SLOT_W-1:0]     req_slot;
    logic                  pool_full;

    // Map table and key to a bucket slot
    assign req_table_ok = (32'(req_item.table_select) < TABLES);
    assign req_slot     = SLOT_W'(32'(req_item.table_select) * BUCKETS
                                  + req_item.object_key % BUCKETS);
    assign pool_full    = (alloc_count_reg == POOL_CNT_W'(POOL_ENTRIES));

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_item_reg;

    // Sequence lookup, walk, insert and result transfer
    always_comb
    begin
        state_next       = state_reg;
        key_next         = key_reg;
        slot_next        = slot_reg;
        head_valid_next  = head_valid_reg;
        head_index_next  = head_index_reg;
        alloc_count_next = alloc_count_reg;
        result_next      = result_reg;
        rsp_valid_next   = rsp_valid_reg && rsp_stall;
        rsp_item_next    = rsp_item_reg;
        head_cmd         = '0;
        entry_cmd        = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    key_next  = req_item.object_key;
                    slot_next = req_slot;
                    if (req_table_ok)
                    begin
                        head_cmd.rd_en   = 1'b1;
                        head_cmd.rd_addr = req_slot;
                        state_next       = S_HEAD;
                    end
                    else
                    begin
                        result_next = '0;
                        state_next  = S_FINISH;
                    end
                end
            end
            S_HEAD:
            begin
                head_valid_next = head_rsp.valid;
                head_index_next = head_rsp.index;
                if (head_rsp.valid)
                begin
                    entry_cmd.rd_en   = 1'b1;
                    entry_cmd.rd_addr = head_rsp.index;
                    state_next        = S_WALK;
                end
                else
                begin
                    state_next = S_INSERT;
                end
            end
            S_WALK:
            begin
                if (entry_rdata.key == key_reg)
                begin
                    result_next = '0;
                    state_next  = S_FINISH;
                end
                else if (entry_rdata.link_valid)
                begin
                    entry_cmd.rd_en   = 1'b1;
                    entry_cmd.rd_addr = entry_rdata.link;
                end
                else
                begin
                    state_next = S_INSERT;
                end
            end
            S_INSERT:
            begin
                if (pool_full)
                begin
                    result_next = '{is_new: 1'b0, dropped: 1'b1};
                end
                else
                begin
                    // Link the fresh entry in as the new chain head
                    entry_cmd.wr_en              = 1'b1;
                    entry_cmd.wr_addr            = alloc_count_reg[POOL_IDX_W-1:0];
                    entry_cmd.wr_data.key        = key_reg;
                    entry_cmd.wr_data.link_valid = head_valid_reg;
                    entry_cmd.wr_data.link       = head_index_reg;
                    head_cmd.wr_en               = 1'b1;
                    head_cmd.wr_addr             = slot_reg;
                    head_cmd.wr_index            = alloc_count_reg[POOL_IDX_W-1:0];
                    alloc_count_next             = alloc_count_reg + 1'b1;
                    result_next                  = '{is_new: 1'b1, dropped: 1'b0};
                end
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_item_next  = result_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            alloc_count_reg <= '0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            alloc_count_reg <= alloc_count_next;
            rsp_valid_reg   <= rsp_valid_next;
            key_reg         <= key_next;
            slot_reg        <= slot_next;
            head_valid_reg  <= head_valid_next;
            head_index_reg  <= head_index_next;
            result_reg      <= result_next;
            rsp_item_reg    <= rsp_item_next;
        end
    end

    `CHS_ASSERT_IMP(a_alloc_bound, 1'b1, alloc_count_reg <= POOL_CNT_W'(POOL_ENTRIES))
    `CHS_ASSERT_IMP(a_insert_pair, 1'b1, head_cmd.wr_en == entry_cmd.wr_en)
    `CHS_ASSERT_NEXT(a_alloc_step, entry_cmd.wr_en, alloc_count_reg == $past(alloc_count_reg) + 1'b1)
    `CHS_ASSERT_IMP(a_drop_full, rsp_valid && rsp_item.dropped, pool_full && !rsp_item.is_new)

endmodule

[sim/tb_chained_hash_set_insert_if_absent_top.sv]
// Testbench for the chained hash set insert-if-absent block: self-checking, random stalls
`timescale 1ns / 1ps

module tb_chained_hash_set_insert_if_absent_top;
    import chs_pkg::*;

    localparam int RANDOM_ITEMS   = 400;
    localparam int IDLE_PCT       = 27;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 40;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int MAX_PRINTED    = 30;

    // Shadow copy of the tables and the pool; predicts the outcome of each key offered
    class insert_outcome_tracker;
        bit                  head_ok  [SLOTS];
        bit [POOL_IDX_W-1:0] head_at  [SLOTS];
        bit [KEY_W-1:0]      pool_key [POOL_ENTRIES];
        bit                  link_ok  [POOL_ENTRIES];
        bit [POOL_IDX_W-1:0] link_at  [POOL_ENTRIES];
        int unsigned         used;
        chs_rsp_t            outcome_q[$];
        int unsigned         mismatches;
        int unsigned         inserts;
        int unsigned         hits;
        int unsigned         drops;
        int unsigned         results;

        // Walk one chain from its head, following valid links only
        function bit key_on_chain(int slot, bit [KEY_W-1:0] key);
            bit                  ok;
            bit [POOL_IDX_W-1:0] at;
            ok = head_ok[slot];
            at = head_at[slot];
            for (int n = 0; ok && n < POOL_ENTRIES; n++)
            begin
                if (pool_key[at] == key)
                    return 1'b1;
                ok = link_ok[at];
                at = link_at[at];
            end
            return 1'b0;
        endfunction

        // Apply one accepted transfer in and queue the result it must produce
        function void note_offer(chs_req_t r);
            chs_rsp_t o;
            int       slot;
            o    = '0;
            slot = int'(r.table_select) * BUCKETS + int'(r.object_key % 32'(BUCKETS));
            if (key_on_chain(slot, r.object_key))
            begin
                hits++;
            end
            else if (used >= POOL_ENTRIES)
            begin
                o.dropped = 1'b1;
                drops++;
            end
            else
            begin
                // Link the next pool entry in as the new chain head
                pool_key[used] = r.object_key;
                link_ok[used]  = head_ok[slot];
                link_at[used]  = head_at[slot];
                head_ok[slot]  = 1'b1;
                head_at[slot]  = POOL_IDX_W'(used);
                used++;
                o.is_new = 1'b1;
                inserts++;
            end
            outcome_q.push_back(o);
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            if (mismatches <= MAX_PRINTED)
                $display("mismatch at %0t: %s", $realtime, msg);
        endtask

        // Compare one accepted transfer out with the oldest prediction
        task check_outcome(chs_rsp_t got);
            chs_rsp_t want;
            results++;
            if (outcome_q.size() == 0)
            begin
                report_mismatch($sformatf("result %0d arrived with none expected", results));
            end
            else
            begin
                want = outcome_q.pop_front();
                if (got.is_new !== want.is_new)
                    report_mismatch($sformatf("result %0d is_new %b, expected %b",
                                              results, got.is_new, want.is_new));
                if (got.dropped !== want.dropped)
                    report_mismatch($sformatf("result %0d dropped %b, expected %b",
                                              results, got.dropped, want.dropped));
            end
        endtask
    endclass

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     req_valid = 1'b0;
    logic     req_stall;
    chs_req_t req_item  = '0;
    logic     rsp_valid;
    logic     rsp_stall = 1'b0;
    chs_rsp_t rsp_item;

    insert_outcome_tracker tracker = new;
    chs_req_t              offered_q[$];
    bit                    steady  = 1'b0;
    bit                    hold_go = 1'b0;
    int                    hold_left;
    int                    stuck_cycles;
    int                    n;

    // Extremes, a shared table, deep chains and lookups at head, middle and tail
    chs_req_t directed_items [18] = '{
        '{2'd0, 32'h0000_0000}, '{2'd0, 32'h0000_0000}, '{2'd1, 32'h0000_0000},
        '{2'd2, 32'hFFFF_FFFF}, '{2'd3, 32'hFFFF_FFFF}, '{2'd3, 32'hFFFF_FFFF},
        '{2'd0, 32'd32},        '{2'd0, 32'd64},        '{2'd0, 32'd96},
        '{2'd0, 32'd128},       '{2'd0, 32'h0000_0000}, '{2'd0, 32'd64},
        '{2'd0, 32'd160},       '{2'd1, 32'h8000_0000}, '{2'd2, 32'd31},
        '{2'd2, 32'h7FFF_FFFF}, '{2'd2, 32'd31},        '{2'd1, 32'h7FFF_FFFF}
    };

    chained_hash_set_insert_if_absent_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_item  (req_item),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_item  (rsp_item)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Record every transfer in and check every transfer out
    always @(posedge clk)
    begin
        if (rst_n && req_valid && !req_stall)
            tracker.note_offer(req_item);
        if (rst_n && rsp_valid && !rsp_stall)
            tracker.check_outcome(rsp_item);
    end

    // Receiver: random stalls, a steady stretch, and one long hold-off
    always @(posedge clk)
    begin
        if (hold_go)
        begin
            hold_go   = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            rsp_stall <= 1'b1;
        end
        else if (steady)
            rsp_stall <= 1'b0;
        else
            rsp_stall <= ($urandom_range(99) < IDLE_PCT);
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                stuck_cycles <= 0;
            else
                stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles >= WATCHDOG_LIMIT)
            begin
                $display("timeout: no transfer in %0d cycles", WATCHDOG_LIMIT);
                $display("FAIL chained_hash_set_insert_if_absent_top");
                $finish;
            end
        end
    end

    // Mix of repeated keys, same key in another table, bucket neighbors and fresh keys
    function automatic chs_req_t make_item();
        chs_req_t r;
        chs_req_t old;
        int       pick;
        r.table_select = TABLE_W'($urandom_range(TABLES - 1));
        r.object_key   = $urandom();
        if (offered_q.size() == 0)
            return r;
        old  = offered_q[$urandom_range(offered_q.size() - 1)];
        pick = $urandom_range(99);
        if (pick < 35)
        begin
            r = old;
        end
        else if (pick < 45)
        begin
            r.object_key = old.object_key;
        end
        else if (pick < 60)
        begin
            r.table_select = old.table_select;
            r.object_key   = old.object_key + 32'(BUCKETS) * $urandom_range(1, 64);
        end
        return r;
    endfunction

    // Offer one item after a random gap and hold it until the transfer
    task automatic offer_item(input chs_req_t r);
        int gap;
        gap = 0;
        if (!steady)
            while ($urandom_range(99) < IDLE_PCT)
                gap++;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_item  <= r;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        offered_q.push_back(r);
    endtask

    // Drop valid and wait until every predicted result has been checked
    task automatic wait_for_outcomes();
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (tracker.outcome_q.size() != 0);
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_items[i])
            offer_item(directed_items[i]);

        // Random part: a steady stretch, one long hold-off and one full drain
        n = 0;
        while (n < RANDOM_ITEMS)
        begin
            steady = (n >= 100 && n < 180);
            if (n == 40)
                hold_go = 1'b1;
            if (n == 250)
                wait_for_outcomes();
            offer_item(make_item());
            n++;
        end

        wait_for_outcomes();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("offered %0d keys: %0d inserted, %0d already present, %0d turned away",
                 offered_q.size(), tracker.inserts, tracker.hits, tracker.drops);
        $display("checked %0d results, %0d mismatches, pool entries in use %0d of %0d",
                 tracker.results, tracker.mismatches, tracker.used, POOL_ENTRIES);
        if (tracker.mismatches == 0 && tracker.outcome_q.size() == 0)
            $display("PASS chained_hash_set_insert_if_absent_top");
        else
            $display("FAIL chained_hash_set_insert_if_absent_top");
        $finish;
    end

endmodule

[sim.f]
+incdir+design
design/chs_pkg.sv
design/chs_ram.sv
design/chs_walk_ctrl.sv
design/chained_hash_set_insert_if_absent_top.sv
sim/tb_chained_hash_set_insert_if_absent_top.sv
